// ----- rtl/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants for the closest pair finder
// Point store sizing, result status codes and controller states.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int unsigned MaxPoints  = 16;
  localparam int unsigned MaxPairs   = 64;
  localparam int unsigned CoordWidth = 24;
  localparam int unsigned IdxW       = $clog2(MaxPoints);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned DiffW      = CoordWidth + 1;
  localparam int unsigned SqW        = 2 * DiffW;
  localparam int unsigned DistW      = SqW + 1;
  localparam int unsigned RootW      = 25;
  localparam int unsigned OutDistW   = 49;
  localparam int unsigned EmitW      = $clog2(MaxPairs + 1);
  localparam int unsigned PairW      = $clog2(MaxPairs);

  typedef enum logic [1:0] {
    StatusPair     = 2'd0,
    StatusTooFew   = 2'd1,
    StatusTooMany  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    StLoad,
    StRead,
    StDiff,
    StSquare,
    StSum,
    StRoot,
    StEmit,
    StError
  } state_e;

endpackage

// ----- rtl/cpf_sqrt.sv -----
// ----------------------------------------------------------------------------
// cpf_sqrt: iterative integer square root
// One result bit per cycle, restoring method over a DistW-bit radicand.
// ----------------------------------------------------------------------------
module cpf_sqrt
  import cpf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DistW-1:0]        value_i,
  output logic                    busy_o,
  output logic [RootW-1:0]        root_o
);

  localparam int unsigned RadW   = DistW + 1;
  localparam int unsigned Steps  = RadW / 2;
  localparam int unsigned StepW  = $clog2(Steps + 1);

  logic [RadW-1:0]  rad_q;
  logic [Steps+1:0] rem_q;
  logic [Steps-1:0] res_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q;

  logic [Steps+1:0] trial;
  logic [Steps+1:0] shifted;

  // Bring down two radicand bits and try subtracting 4*res+1
  always_comb begin
    shifted = {rem_q[Steps-1:0], rad_q[RadW-1 -: 2]};
    trial   = {res_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= StepW'(Steps);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= {1'b0, value_i};
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_q <= shifted - trial;
        res_q <= {res_q[Steps-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        res_q <= {res_q[Steps-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ----- rtl/closest_pair_finder.sv -----
// ----------------------------------------------------------------------------
// closest_pair_finder: brute force closest pair of 2D points
// Stores a set of points, then finds the minimum squared distance and emits
// up to MaxPairs pairs at that distance in row-major order, or one error result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  point     in         valid_i / stall_o   x_coord_i y_coord_i last_point_i
//  result    out        valid_o / stall_i   status_o .. last_result_o
//
//  A point that is not last is stored without stalling the input. A last
//  point starts two passes over the n*(n-1)/2 pairs; each pair reads its
//  two points through the single read port of the point memory. The square
//  root of the minimum runs between the passes. Each pair result is read
//  from the result memory and then presented, held while stalled. An error
//  result is presented the cycle after the last point. The input stays
//  stalled until the final result of the set is taken. Reset clears only
//  control state; the memories need no clearing.
// ----------------------------------------------------------------------------
module closest_pair_finder
  import cpf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [CoordWidth-1:0] x_coord_i,
  input  logic [CoordWidth-1:0] y_coord_i,
  input  logic                  last_point_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [1:0]            status_o,
  output logic [OutDistW-1:0]   min_dist_squared_o,
  output logic [RootW-1:0]      min_distance_o,
  output logic [3:0]            first_index_o,
  output logic [3:0]            second_index_o,
  output logic [6:0]            pair_count_o,
  output logic                  truncated_o,
  output logic                  last_result_o
);

  state_e state_q, state_d;

  logic [2*CoordWidth-1:0] mem_q [MaxPoints];
  logic [2*CoordWidth-1:0] rd_q;
  logic [2*CoordWidth-1:0] pi_q;
  logic [IdxW-1:0]         rd_addr;
  logic                    rd_en;

  // Index pairs at the minimum, drained once the full count is known
  logic [2*IdxW-1:0] res_mem [MaxPairs];
  logic [2*IdxW-1:0] res_q;
  logic [EmitW-1:0]  rptr_q;
  logic              fill_q;     // res_q holds the entry at rptr_q

  logic [CntW-1:0]  count_q;
  logic             over_q;
  logic [IdxW-1:0]  i_q, j_q;
  logic             second_q;    // 0 minimum pass, 1 match pass
  logic             phase_q;     // 0 read point i, 1 read point j
  logic [DistW-1:0] min_q;
  logic [DiffW-1:0] dx_q, dy_q;
  logic [SqW-1:0]   sx_q, sy_q;
  logic [DistW-1:0] dist_sum;
  logic [7:0]       total_q;
  logic [EmitW-1:0] emitted_q;
  logic [RootW-1:0] root;
  logic [RootW-1:0] root_q;
  logic             sq_start, sq_busy;
  logic             accept, out_take, last_pair, is_match, store_pair;

  assign accept     = valid_i && !stall_o;
  assign out_take   = valid_o && !stall_i;
  assign stall_o    = (state_q != StLoad);
  assign dist_sum   = DistW'(sx_q) + DistW'(sy_q);
  assign is_match   = (dist_sum == min_q);
  assign last_pair  = (j_q == IdxW'(count_q - CntW'(1)))
                   && (i_q == IdxW'(count_q - CntW'(2)));
  assign store_pair = (state_q == StSum) && second_q && is_match
                   && (emitted_q < EmitW'(MaxPairs));

  // Point memory: write on load, one registered read
  assign rd_en   = (state_q == StRead);
  assign rd_addr = phase_q ? j_q : i_q;
  always_ff @(posedge clk_i) begin
    if (accept && count_q < CntW'(MaxPoints)) begin
      mem_q[count_q[IdxW-1:0]] <= {x_coord_i, y_coord_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Result memory: write matches, read the drain pointer every cycle
  always_ff @(posedge clk_i) begin
    if (store_pair) begin
      res_mem[emitted_q[PairW-1:0]] <= {i_q, j_q};
    end
    res_q <= res_mem[rptr_q[PairW-1:0]];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (accept && last_point_i) begin
          if (over_q || count_q == CntW'(MaxPoints)) state_d = StError;
          else if (count_q == '0) state_d = StError;
          else state_d = StRead;
        end
      end
      StRead:   state_d = phase_q ? StDiff : StRead;
      StDiff:   state_d = StSquare;
      StSquare: state_d = StSum;
      StSum: begin
        if (!last_pair) state_d = StRead;
        else if (!second_q) state_d = StRoot;
        else state_d = StEmit;
      end
      StRoot:   state_d = sq_busy ? StRoot : StRead;
      StEmit:   state_d = (out_take && last_result_o) ? StLoad : StEmit;
      StError:  state_d = out_take ? StLoad : StError;
      default:  state_d = StLoad;
    endcase
  end

  // Start the square root on the last pair of the minimum pass
  assign sq_start = (state_q == StSum) && !second_q && last_pair;

  cpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (dist_sum < min_q ? dist_sum : min_q),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // Datapath: differences, squares, root capture
  always_ff @(posedge clk_i) begin
    if (state_q == StRead && phase_q) pi_q <= rd_q;
    if (state_q == StDiff) begin
      dx_q <= DiffW'($signed(pi_q[2*CoordWidth-1 -: CoordWidth]))
            - DiffW'($signed(rd_q[2*CoordWidth-1 -: CoordWidth]));
      dy_q <= DiffW'($signed(pi_q[CoordWidth-1:0]))
            - DiffW'($signed(rd_q[CoordWidth-1:0]));
    end
    if (state_q == StSquare) begin
      sx_q <= SqW'($signed(dx_q) * $signed(dx_q));
      sy_q <= SqW'($signed(dy_q) * $signed(dy_q));
    end
    if (state_q == StRoot && !sq_busy) root_q <= root;
  end

  // Control: pair walk, minimum, counts, drain pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      count_q   <= '0;
      over_q    <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      second_q  <= 1'b0;
      phase_q   <= 1'b0;
      min_q     <= '1;
      total_q   <= '0;
      emitted_q <= '0;
      rptr_q    <= '0;
      fill_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (count_q < CntW'(MaxPoints)) count_q <= count_q + CntW'(1);
            else over_q <= 1'b1;
            if (last_point_i) begin
              i_q       <= '0;
              j_q       <= IdxW'(1);
              phase_q   <= 1'b0;
              second_q  <= 1'b0;
              min_q     <= '1;
              total_q   <= '0;
              emitted_q <= '0;
              rptr_q    <= '0;
              fill_q    <= 1'b0;
            end
          end
        end
        StRead: phase_q <= ~phase_q;
        StSum: begin
          if (!second_q) begin
            if (dist_sum < min_q) min_q <= dist_sum;
          end else if (is_match) begin
            if (total_q != 8'hff) total_q <= total_q + 8'd1;
            if (emitted_q < EmitW'(MaxPairs)) emitted_q <= emitted_q + EmitW'(1);
          end
          if (last_pair) begin
            i_q <= '0;
            j_q <= IdxW'(1);
          end else if (j_q == IdxW'(count_q - CntW'(1))) begin
            i_q <= i_q + IdxW'(1);
            j_q <= i_q + IdxW'(2);
          end else begin
            j_q <= j_q + IdxW'(1);
          end
        end
        StRoot: if (!sq_busy) second_q <= 1'b1;
        StEmit: begin
          if (out_take) begin
            rptr_q <= rptr_q + EmitW'(1);
            fill_q <= 1'b0;
          end else begin
            fill_q <= 1'b1;
          end
          if (out_take && last_result_o) begin
            count_q <= '0;
            over_q  <= 1'b0;
          end
        end
        StError: begin
          if (out_take) begin
            count_q <= '0;
            over_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output fields
  assign valid_o = (state_q == StError) || ((state_q == StEmit) && fill_q);
  always_comb begin
    status_o           = 2'(StatusPair);
    min_dist_squared_o = min_q[OutDistW-1:0];
    min_distance_o     = root_q;
    first_index_o      = 4'(res_q[2*IdxW-1 -: IdxW]);
    second_index_o     = 4'(res_q[IdxW-1:0]);
    pair_count_o       = total_q > 8'd127 ? 7'd127 : total_q[6:0];
    truncated_o        = total_q > 8'(MaxPairs);
    last_result_o      = (rptr_q + EmitW'(1) == emitted_q);
    if (state_q == StError) begin
      status_o           = over_q ? 2'(StatusTooMany) : 2'(StatusTooFew);
      min_dist_squared_o = '0;
      min_distance_o     = '0;
      first_index_o      = '0;
      second_index_o     = '0;
      pair_count_o       = '0;
      truncated_o        = 1'b0;
      last_result_o      = 1'b1;
    end
  end

  // Checks
  a_no_input_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> stall_o) else $error("input taken during search");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints)) else $error("point count overrun");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= EmitW'(MaxPairs)) else $error("emitted count overrun");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o) else $error("stalled result dropped");

endmodule
